// ----- design/tpba_pkg.sv -----
// ---------------------------------------------------------------------------
// tpba_pkg
// Shared types, codes and defaults for the two-pool block allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package tpba_pkg;

    // default pool geometry
    localparam int unsigned SMALL_BLOCKS_DEF      = 1024;
    localparam int unsigned LARGE_BLOCKS_DEF      = 128;
    localparam int unsigned SMALL_BLOCK_BYTES_DEF = 16;
    localparam int unsigned LARGE_BLOCK_BYTES_DEF = 184;

    // configuration reset values
    localparam logic [4:0]  SMALL_LIMIT_RST = 5'd15;
    localparam logic [7:0]  LARGE_LIMIT_RST = 8'd180;
    localparam logic [31:0] SMALL_BASE_RST  = 32'd4096;
    localparam logic [31:0] LARGE_BASE_RST  = 32'd65536;

    // block index field in the command queue, wide enough for pools of up to 131071 blocks
    localparam int unsigned CMD_IDX_W = 17;
    localparam int unsigned Q_DEPTH   = 2;

    typedef enum logic [1:0] {
        CFG_SMALL_LIMIT = 2'd0,
        CFG_LARGE_LIMIT = 2'd1,
        CFG_SMALL_BASE  = 2'd2,
        CFG_LARGE_BASE  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_ALLOC   = 2'd0,
        ST_FAIL    = 2'd1,
        ST_FREED   = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_ALLOC_S    = 3'd0,
        CMD_ALLOC_L    = 3'd1,
        CMD_ALLOC_FAIL = 3'd2,
        CMD_FREE_S     = 3'd3,
        CMD_FREE_L     = 3'd4,
        CMD_FREE_IGN   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        BS_CLEAR = 2'd0,
        BS_RUN   = 2'd1,
        BS_POP   = 2'd2
    } t_bstate;

    typedef struct packed {
        logic [4:0]  small_limit;
        logic [7:0]  large_limit;
        logic [31:0] small_base;
        logic [31:0] large_base;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic [31:0] request_size;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic [31:0] block_address;
        t_status     status;
    } t_rsp;

    typedef struct packed {
        t_cmd                 kind;
        logic [CMD_IDX_W-1:0] idx;
    } t_cmd_item;

endpackage

`default_nettype wire

// ----- design/tpba_pool_match.sv -----
// ---------------------------------------------------------------------------
// tpba_pool_match
// Maps a pool offset to a block index: reciprocal multiply, then an exact
// check of the two candidate quotients against the offset.
// ---------------------------------------------------------------------------
`default_nettype none

module tpba_pool_match #(
    parameter int unsigned BLOCKS = tpba_pkg::SMALL_BLOCKS_DEF,
    parameter int unsigned BYTES  = tpba_pkg::SMALL_BLOCK_BYTES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_load,
    input  wire logic [31:0]                  i_off,
    output logic                              o_hit,
    output logic [$clog2(BLOCKS + 1)-1:0]     o_idx
);

    localparam int unsigned IW = $clog2(BLOCKS + 1);
    localparam int unsigned MW = 34 - $clog2(BYTES);
    localparam int unsigned DW = $clog2(BYTES + 1);
    localparam int unsigned PW = IW + DW;
    localparam int unsigned XW = (PW > 33) ? PW : 33;
    localparam longint unsigned RECIP = ((64'd1 << 32) + 64'(BYTES) - 64'd1) / 64'(BYTES);
    localparam logic [MW-1:0] M    = MW'(RECIP);
    localparam logic [DW-1:0] D    = DW'(BYTES);
    localparam logic [32:0]   SPAN = 33'(64'(BLOCKS) * 64'(BYTES));

    logic [31+MW:0] w_prod;
    logic [PW-1:0]  w_p;
    logic [XW-1:0]  w_px;
    logic [XW-1:0]  w_offx;
    logic           w_hit0;
    logic           w_hit1;

    logic [31:0]    r_off;
    logic           r_in_span;
    logic [IW-1:0]  r_q;

    // quotient estimate is exact or one too large
    assign w_prod = (32 + MW)'(i_off) * (32 + MW)'(M);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_off     <= i_off;
            r_in_span <= ({1'b0, i_off} < SPAN);
            r_q       <= w_prod[32 +: IW];
        end
    end

    assign w_p    = PW'(r_q) * PW'(D);
    assign w_px   = XW'(w_p);
    assign w_offx = XW'(r_off);
    assign w_hit0 = (w_px == w_offx);
    assign w_hit1 = ((w_px - XW'(D)) == w_offx);

    assign o_hit = r_in_span && (w_hit0 || w_hit1);
    assign o_idx = w_hit0 ? r_q : (r_q - IW'(1));

endmodule

`default_nettype wire

// ----- design/tpba_front.sv -----
// ---------------------------------------------------------------------------
// tpba_front
// Accepts items, picks the pool and decodes free addresses into block
// indices over two stages, then queues one command per item.
// ---------------------------------------------------------------------------
`default_nettype none

module tpba_front #(
    parameter int unsigned SMALL_BLOCKS      = tpba_pkg::SMALL_BLOCKS_DEF,
    parameter int unsigned LARGE_BLOCKS      = tpba_pkg::LARGE_BLOCKS_DEF,
    parameter int unsigned SMALL_BLOCK_BYTES = tpba_pkg::SMALL_BLOCK_BYTES_DEF,
    parameter int unsigned LARGE_BLOCK_BYTES = tpba_pkg::LARGE_BLOCK_BYTES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tpba_pkg::t_cfg      i_cfg,
    input  wire logic                i_req_valid,
    input  wire tpba_pkg::t_req      i_req,
    output logic                     o_req_stall,
    input  wire logic                i_clear_busy,
    output logic                     o_cmd_push,
    output tpba_pkg::t_cmd_item      o_cmd,
    input  wire logic                i_cmd_full
);

    localparam int unsigned SIW = $clog2(SMALL_BLOCKS + 1);
    localparam int unsigned LIW = $clog2(LARGE_BLOCKS + 1);

    logic              w_accept;
    logic              w_s1_move;
    logic              w_s2_take;
    logic [31:0]       w_size;
    tpba_pkg::t_cmd    w_kind;
    logic              w_hit_s;
    logic              w_hit_l;
    logic [SIW-1:0]    w_idx_s;
    logic [LIW-1:0]    w_idx_l;

    logic              r_init;
    logic              r_s1_v;
    logic              r_s1_op;
    tpba_pkg::t_cmd    r_s1_kind;
    logic              r_s1_free_ok;
    logic [31:0]       r_s1_off_s;
    logic [31:0]       r_s1_off_l;
    logic              r_s2_v;
    logic              r_s2_op;
    tpba_pkg::t_cmd    r_s2_kind;
    logic              r_s2_free_ok;

    assign o_cmd_push  = r_s2_v && !i_cmd_full;
    assign w_s2_take   = !r_s2_v || o_cmd_push;
    assign w_s1_move   = r_s1_v && w_s2_take;
    assign o_req_stall = (r_s1_v && !w_s1_move) || i_clear_busy;
    assign w_accept    = i_req_valid && !o_req_stall;

    // a zero size counts as one byte
    assign w_size = (i_req.request_size == '0) ? 32'd1 : i_req.request_size;

    always_comb begin
        if (w_size <= 32'(i_cfg.small_limit)) begin
            w_kind = tpba_pkg::CMD_ALLOC_S;
        end else if (w_size <= 32'(i_cfg.large_limit)) begin
            w_kind = tpba_pkg::CMD_ALLOC_L;
        end else begin
            w_kind = tpba_pkg::CMD_ALLOC_FAIL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (w_accept && (i_req.op == tpba_pkg::OP_ALLOC)) begin
                r_init <= 1'b1;
            end
            if (w_accept) begin
                r_s1_v <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (w_s1_move) begin
                r_s2_v <= 1'b1;
            end else if (o_cmd_push) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op      <= i_req.op;
            r_s1_kind    <= w_kind;
            // frees before the first allocate and null frees are ignored
            r_s1_free_ok <= (i_req.address != '0) && r_init;
            r_s1_off_s   <= i_req.address - i_cfg.small_base;
            r_s1_off_l   <= i_req.address - i_cfg.large_base;
        end
        if (w_s1_move) begin
            r_s2_op      <= r_s1_op;
            r_s2_kind    <= r_s1_kind;
            r_s2_free_ok <= r_s1_free_ok;
        end
    end

    tpba_pool_match #(
        .BLOCKS (SMALL_BLOCKS),
        .BYTES  (SMALL_BLOCK_BYTES)
    ) u_match_s (
        .i_clk  (i_clk),
        .i_load (w_s1_move),
        .i_off  (r_s1_off_s),
        .o_hit  (w_hit_s),
        .o_idx  (w_idx_s)
    );

    tpba_pool_match #(
        .BLOCKS (LARGE_BLOCKS),
        .BYTES  (LARGE_BLOCK_BYTES)
    ) u_match_l (
        .i_clk  (i_clk),
        .i_load (w_s1_move),
        .i_off  (r_s1_off_l),
        .o_hit  (w_hit_l),
        .o_idx  (w_idx_l)
    );

    // small pool wins where the pools overlap
    always_comb begin
        o_cmd.idx = '0;
        if (r_s2_op == tpba_pkg::OP_ALLOC) begin
            o_cmd.kind = r_s2_kind;
        end else if (r_s2_free_ok && w_hit_s) begin
            o_cmd.kind = tpba_pkg::CMD_FREE_S;
            o_cmd.idx  = tpba_pkg::CMD_IDX_W'(w_idx_s);
        end else if (r_s2_free_ok && w_hit_l) begin
            o_cmd.kind = tpba_pkg::CMD_FREE_L;
            o_cmd.idx  = tpba_pkg::CMD_IDX_W'(w_idx_l);
        end else begin
            o_cmd.kind = tpba_pkg::CMD_FREE_IGN;
        end
    end

endmodule

`default_nettype wire

// ----- design/tpba_cmd_q.sv -----
// ---------------------------------------------------------------------------
// tpba_cmd_q
// Short command queue between the decode front and the free-list back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tpba_cmd_q (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire tpba_pkg::t_cmd_item  i_item,
    input  wire logic                 i_pop,
    output logic                      o_full,
    output logic                      o_valid,
    output tpba_pkg::t_cmd_item       o_item
);

    localparam int unsigned PTR_W = (tpba_pkg::Q_DEPTH > 1) ? $clog2(tpba_pkg::Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(tpba_pkg::Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(tpba_pkg::Q_DEPTH - 1);

    tpba_pkg::t_cmd_item r_mem [tpba_pkg::Q_DEPTH];
    logic [PTR_W-1:0]    r_wp;
    logic [PTR_W-1:0]    r_rp;
    logic [CNT_W-1:0]    r_cnt;

    assign o_full  = (r_cnt == CNT_W'(tpba_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/tpba_back.sv -----
// ---------------------------------------------------------------------------
// tpba_back
// Free-list engine: next-index memories and heads of both pools, the
// post-reset chain fill, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tpba_back #(
    parameter int unsigned SMALL_BLOCKS      = tpba_pkg::SMALL_BLOCKS_DEF,
    parameter int unsigned LARGE_BLOCKS      = tpba_pkg::LARGE_BLOCKS_DEF,
    parameter int unsigned SMALL_BLOCK_BYTES = tpba_pkg::SMALL_BLOCK_BYTES_DEF,
    parameter int unsigned LARGE_BLOCK_BYTES = tpba_pkg::LARGE_BLOCK_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [31:0]          i_small_base,
    input  wire logic [31:0]          i_large_base,
    input  wire logic                 i_cmd_valid,
    input  wire tpba_pkg::t_cmd_item  i_cmd,
    output logic                      o_cmd_pop,
    output logic                      o_clear_busy,
    output logic                      o_rsp_valid,
    output tpba_pkg::t_rsp            o_rsp,
    input  wire logic                 i_rsp_stall
);

    localparam int unsigned SIW  = $clog2(SMALL_BLOCKS + 1);
    localparam int unsigned LIW  = $clog2(LARGE_BLOCKS + 1);
    localparam int unsigned SAW  = (SMALL_BLOCKS > 1) ? $clog2(SMALL_BLOCKS) : 1;
    localparam int unsigned LAW  = (LARGE_BLOCKS > 1) ? $clog2(LARGE_BLOCKS) : 1;
    localparam int unsigned MAXB = (SMALL_BLOCKS > LARGE_BLOCKS) ? SMALL_BLOCKS : LARGE_BLOCKS;
    localparam int unsigned CW   = (MAXB > 1) ? $clog2(MAXB) : 1;
    localparam logic [31:0] SB32 = 32'(SMALL_BLOCK_BYTES);
    localparam logic [31:0] LB32 = 32'(LARGE_BLOCK_BYTES);

    logic [SIW-1:0]     r_s_mem [SMALL_BLOCKS];
    logic [LIW-1:0]     r_l_mem [LARGE_BLOCKS];
    logic [SIW-1:0]     r_s_rd;
    logic [LIW-1:0]     r_l_rd;

    tpba_pkg::t_bstate  r_state, n_state;
    logic [CW-1:0]      r_clr, n_clr;
    logic [SIW-1:0]     r_s_head, n_s_head;
    logic [LIW-1:0]     r_l_head, n_l_head;
    logic               r_pool_l, n_pool_l;
    logic               r_out_v, n_out_v;
    tpba_pkg::t_rsp     r_out, n_out;

    logic               w_out_free;
    logic [SIW-1:0]     w_s_idx;
    logic [LIW-1:0]     w_l_idx;
    logic               w_s_we, w_l_we;
    logic [SAW-1:0]     w_s_waddr;
    logic [LAW-1:0]     w_l_waddr;
    logic [SIW-1:0]     w_s_wdata;
    logic [LIW-1:0]     w_l_wdata;
    logic               w_s_re, w_l_re;

    assign o_rsp_valid  = r_out_v;
    assign o_rsp        = r_out;
    assign o_clear_busy = (r_state == tpba_pkg::BS_CLEAR);
    assign w_out_free   = !r_out_v || !i_rsp_stall;
    assign w_s_idx      = i_cmd.idx[SIW-1:0];
    assign w_l_idx      = i_cmd.idx[LIW-1:0];

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_s_head  = r_s_head;
        n_l_head  = r_l_head;
        n_pool_l  = r_pool_l;
        n_out_v   = r_out_v && i_rsp_stall;
        n_out     = r_out;
        o_cmd_pop = 1'b0;
        w_s_we    = 1'b0;
        w_l_we    = 1'b0;
        w_s_waddr = '0;
        w_l_waddr = '0;
        w_s_wdata = '0;
        w_l_wdata = '0;
        w_s_re    = 1'b0;
        w_l_re    = 1'b0;
        unique case (r_state)
            tpba_pkg::BS_CLEAR: begin
                // entry i points at i + 1
                w_s_we    = ({1'b0, r_clr} < (CW + 1)'(SMALL_BLOCKS));
                w_l_we    = ({1'b0, r_clr} < (CW + 1)'(LARGE_BLOCKS));
                w_s_waddr = r_clr[SAW-1:0];
                w_l_waddr = r_clr[LAW-1:0];
                w_s_wdata = SIW'({1'b0, r_clr} + (CW + 1)'(1));
                w_l_wdata = LIW'({1'b0, r_clr} + (CW + 1)'(1));
                if (r_clr == CW'(MAXB - 1)) begin
                    n_state = tpba_pkg::BS_RUN;
                end else begin
                    n_clr = r_clr + CW'(1);
                end
            end
            tpba_pkg::BS_RUN: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_pop = 1'b1;
                    n_out.block_address = '0;
                    unique case (i_cmd.kind)
                        tpba_pkg::CMD_ALLOC_S: begin
                            if (r_s_head == SIW'(SMALL_BLOCKS)) begin
                                n_out_v      = 1'b1;
                                n_out.status = tpba_pkg::ST_FAIL;
                            end else begin
                                w_s_re   = 1'b1;
                                n_pool_l = 1'b0;
                                n_state  = tpba_pkg::BS_POP;
                            end
                        end
                        tpba_pkg::CMD_ALLOC_L: begin
                            if (r_l_head == LIW'(LARGE_BLOCKS)) begin
                                n_out_v      = 1'b1;
                                n_out.status = tpba_pkg::ST_FAIL;
                            end else begin
                                w_l_re   = 1'b1;
                                n_pool_l = 1'b1;
                                n_state  = tpba_pkg::BS_POP;
                            end
                        end
                        tpba_pkg::CMD_ALLOC_FAIL: begin
                            n_out_v      = 1'b1;
                            n_out.status = tpba_pkg::ST_FAIL;
                        end
                        tpba_pkg::CMD_FREE_S: begin
                            w_s_we       = 1'b1;
                            w_s_waddr    = w_s_idx[SAW-1:0];
                            w_s_wdata    = r_s_head;
                            n_s_head     = w_s_idx;
                            n_out_v      = 1'b1;
                            n_out.status = tpba_pkg::ST_FREED;
                        end
                        tpba_pkg::CMD_FREE_L: begin
                            w_l_we       = 1'b1;
                            w_l_waddr    = w_l_idx[LAW-1:0];
                            w_l_wdata    = r_l_head;
                            n_l_head     = w_l_idx;
                            n_out_v      = 1'b1;
                            n_out.status = tpba_pkg::ST_FREED;
                        end
                        default: begin
                            n_out_v      = 1'b1;
                            n_out.status = tpba_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            tpba_pkg::BS_POP: begin
                // output register was emptied when the pop was issued
                n_out_v      = 1'b1;
                n_out.status = tpba_pkg::ST_ALLOC;
                if (r_pool_l) begin
                    n_out.block_address = i_large_base + 32'(r_l_head) * LB32;
                    n_l_head            = r_l_rd;
                end else begin
                    n_out.block_address = i_small_base + 32'(r_s_head) * SB32;
                    n_s_head            = r_s_rd;
                end
                n_state = tpba_pkg::BS_RUN;
            end
            default: begin
                n_state = tpba_pkg::BS_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tpba_pkg::BS_CLEAR;
            r_clr    <= '0;
            r_s_head <= '0;
            r_l_head <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_s_head <= n_s_head;
            r_l_head <= n_l_head;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pool_l <= n_pool_l;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_s_we) begin
            r_s_mem[w_s_waddr] <= w_s_wdata;
        end
        if (w_s_re) begin
            r_s_rd <= r_s_mem[r_s_head[SAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_l_we) begin
            r_l_mem[w_l_waddr] <= w_l_wdata;
        end
        if (w_l_re) begin
            r_l_rd <= r_l_mem[r_l_head[LAW-1:0]];
        end
    end

endmodule

`default_nettype wire

// ----- design/two_pool_block_allocator.sv -----
// ---------------------------------------------------------------------------
// two_pool_block_allocator
// Fixed-block allocator with a small and a large pool, each a LIFO free list.
// ---------------------------------------------------------------------------
// After reset the block chains the free lists in its next-index memories,
// with the request stall held high; configuration writes are taken
// throughout. The front end then decodes each item over two register stages
// (pool choice, reciprocal multiply and exactness check of a free address)
// and queues a command. The back end takes one command a cycle for frees and
// failed allocates while the response is not stalled; a successful allocate
// needs a synchronous read of the next-index memory at the pool head
// followed by the head load.
`default_nettype none

module two_pool_block_allocator #(
    parameter int unsigned SMALL_BLOCKS      = tpba_pkg::SMALL_BLOCKS_DEF,
    parameter int unsigned LARGE_BLOCKS      = tpba_pkg::LARGE_BLOCKS_DEF,
    parameter int unsigned SMALL_BLOCK_BYTES = tpba_pkg::SMALL_BLOCK_BYTES_DEF,
    parameter int unsigned LARGE_BLOCK_BYTES = tpba_pkg::LARGE_BLOCK_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data,
    input  wire logic              i_req_valid,
    input  wire tpba_pkg::t_req    i_req,
    output logic                   o_req_stall,
    output logic                   o_rsp_valid,
    output tpba_pkg::t_rsp         o_rsp,
    input  wire logic              i_rsp_stall
);

    tpba_pkg::t_cfg       r_cfg;
    logic                 w_clear_busy;
    logic                 w_cmd_push;
    logic                 w_cmd_pop;
    logic                 w_cmd_full;
    logic                 w_cmd_valid;
    tpba_pkg::t_cmd_item  w_cmd_in;
    tpba_pkg::t_cmd_item  w_cmd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.small_limit <= tpba_pkg::SMALL_LIMIT_RST;
            r_cfg.large_limit <= tpba_pkg::LARGE_LIMIT_RST;
            r_cfg.small_base  <= tpba_pkg::SMALL_BASE_RST;
            r_cfg.large_base  <= tpba_pkg::LARGE_BASE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tpba_pkg::CFG_SMALL_LIMIT: r_cfg.small_limit <= i_cfg_data[4:0];
                tpba_pkg::CFG_LARGE_LIMIT: r_cfg.large_limit <= i_cfg_data[7:0];
                tpba_pkg::CFG_SMALL_BASE:  r_cfg.small_base  <= i_cfg_data;
                tpba_pkg::CFG_LARGE_BASE:  r_cfg.large_base  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tpba_front #(
        .SMALL_BLOCKS      (SMALL_BLOCKS),
        .LARGE_BLOCKS      (LARGE_BLOCKS),
        .SMALL_BLOCK_BYTES (SMALL_BLOCK_BYTES),
        .LARGE_BLOCK_BYTES (LARGE_BLOCK_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_req_valid  (i_req_valid),
        .i_req        (i_req),
        .o_req_stall  (o_req_stall),
        .i_clear_busy (w_clear_busy),
        .o_cmd_push   (w_cmd_push),
        .o_cmd        (w_cmd_in),
        .i_cmd_full   (w_cmd_full)
    );

    tpba_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_item  (w_cmd_in),
        .i_pop   (w_cmd_pop),
        .o_full  (w_cmd_full),
        .o_valid (w_cmd_valid),
        .o_item  (w_cmd_out)
    );

    tpba_back #(
        .SMALL_BLOCKS      (SMALL_BLOCKS),
        .LARGE_BLOCKS      (LARGE_BLOCKS),
        .SMALL_BLOCK_BYTES (SMALL_BLOCK_BYTES),
        .LARGE_BLOCK_BYTES (LARGE_BLOCK_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_small_base (r_cfg.small_base),
        .i_large_base (r_cfg.large_base),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd_out),
        .o_cmd_pop    (w_cmd_pop),
        .o_clear_busy (w_clear_busy),
        .o_rsp_valid  (o_rsp_valid),
        .o_rsp        (o_rsp),
        .i_rsp_stall  (i_rsp_stall)
    );

`ifndef SYNTH
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> !w_cmd_full)
        else $error("command pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("command popped from an empty queue");

    a_no_rsp_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear_busy |-> !o_rsp_valid)
        else $error("result shown while free lists are being chained");

    a_stall_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear_busy |-> o_req_stall)
        else $error("item accepted while free lists are being chained");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_two_pool_block_allocator.sv -----
// ---------------------------------------------------------------------------
// tb_two_pool_block_allocator
// Checks the two-pool allocator against a cycle-free model of both free lists.
// Directed items cover the limits, null/foreign/misaligned frees and frees
// before the first allocate. Random phases drain the small pool, free live and
// stray blocks (double frees included) and sweep the registers. Every
// accepted request is predicted at acceptance and checked against the
// oldest outstanding response.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_two_pool_block_allocator;

    localparam int unsigned N_SMALL   = tpba_pkg::SMALL_BLOCKS_DEF;
    localparam int unsigned N_LARGE   = tpba_pkg::LARGE_BLOCKS_DEF;
    localparam int unsigned S_BYTES   = tpba_pkg::SMALL_BLOCK_BYTES_DEF;
    localparam int unsigned L_BYTES   = tpba_pkg::LARGE_BLOCK_BYTES_DEF;
    localparam int unsigned LARGE_TAG = 32'h0001_0000;
    localparam int unsigned DRAIN_CYC = 16;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned LIMIT     = 400000;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_cfg_we    = 1'b0;
    logic [1:0]      i_cfg_idx   = '0;
    logic [31:0]     i_cfg_data  = '0;
    logic            i_req_valid = 1'b0;
    tpba_pkg::t_req  i_req       = '0;
    logic            o_req_stall;
    logic            o_rsp_valid;
    tpba_pkg::t_rsp  o_rsp;
    logic            i_rsp_stall = 1'b0;

    two_pool_block_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_rsp_stall (i_rsp_stall)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow registers and free lists
    logic [4:0]  cfg_small_limit;
    logic [7:0]  cfg_large_limit;
    logic [31:0] cfg_small_base;
    logic [31:0] cfg_large_base;
    logic [10:0] small_link [N_SMALL];
    logic [7:0]  large_link [N_LARGE];
    logic [10:0] small_top;
    logic [7:0]  large_top;
    bit          alloc_seen;

    // blocks handed out and not yet returned; large ones carry LARGE_TAG
    int unsigned live_blocks [$];

    tpba_pkg::t_req requests_waiting [$];
    tpba_pkg::t_rsp outcomes_due [$];
    int unsigned items_issued   = 0;
    int unsigned items_accepted = 0;
    int unsigned mismatches     = 0;

    bit             req_steady = 1'b0;
    bit             rsp_steady = 1'b0;
    int unsigned    hold_asked = 0;
    int unsigned    hold_taken = 0;
    int unsigned    hold_left  = 0;
    int unsigned    req_gap    = 0;
    int unsigned    rsp_wait   = 0;
    int unsigned    cycles     = 0;
    tpba_pkg::t_rsp rsp_want;

    function automatic int unsigned draw_wait(bit steady);
        if (steady || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 6);
    endfunction

    function automatic logic [31:0] block_addr(int unsigned code);
        if (code >= LARGE_TAG)
            return cfg_large_base + (code - LARGE_TAG) * L_BYTES;
        return cfg_small_base + code * S_BYTES;
    endfunction

    function automatic void forget_block(int unsigned code);
        bit found;
        found = 1'b0;
        for (int i = 0; i < live_blocks.size() && !found; i++) begin
            if (live_blocks[i] == code) begin
                live_blocks.delete(i);
                found = 1'b1;
            end
        end
    endfunction

    // Outcome of one request; updates the shadow free lists.
    function automatic tpba_pkg::t_rsp pool_outcome(tpba_pkg::t_req req);
        tpba_pkg::t_rsp rsp;
        logic [31:0]    size;
        logic [31:0]    off;
        int unsigned    idx;
        rsp.block_address = '0;
        if (req.op == tpba_pkg::OP_ALLOC) begin
            alloc_seen = 1'b1;
            size = (req.request_size == 32'd0) ? 32'd1 : req.request_size;
            rsp.status = tpba_pkg::ST_FAIL;
            if (size <= 32'(cfg_small_limit)) begin
                if (small_top < N_SMALL) begin
                    idx = small_top;
                    rsp.block_address = cfg_small_base + idx * S_BYTES;
                    rsp.status = tpba_pkg::ST_ALLOC;
                    small_top = small_link[idx];
                    live_blocks.push_back(idx);
                end
            end else if (size <= 32'(cfg_large_limit)) begin
                if (large_top < N_LARGE) begin
                    idx = large_top;
                    rsp.block_address = cfg_large_base + idx * L_BYTES;
                    rsp.status = tpba_pkg::ST_ALLOC;
                    large_top = large_link[idx];
                    live_blocks.push_back(LARGE_TAG | idx);
                end
            end
        end else begin
            rsp.status = tpba_pkg::ST_IGNORED;
            if (req.address != 32'd0 && alloc_seen) begin
                // small pool wins where the two overlap
                off = req.address - cfg_small_base;
                if (off < N_SMALL * S_BYTES && off % S_BYTES == 0) begin
                    idx = off / S_BYTES;
                    small_link[idx] = small_top;
                    small_top = 11'(idx);
                    rsp.status = tpba_pkg::ST_FREED;
                    forget_block(idx);
                end else begin
                    off = req.address - cfg_large_base;
                    if (off < N_LARGE * L_BYTES && off % L_BYTES == 0) begin
                        idx = off / L_BYTES;
                        large_link[idx] = large_top;
                        large_top = 8'(idx);
                        rsp.status = tpba_pkg::ST_FREED;
                        forget_block(LARGE_TAG | idx);
                    end
                end
            end
        end
        return rsp;
    endfunction

    function automatic tpba_pkg::t_req alloc_req(logic [31:0] size);
        tpba_pkg::t_req r;
        r.op           = tpba_pkg::OP_ALLOC;
        r.request_size = size;
        r.address      = '0;
        return r;
    endfunction

    function automatic tpba_pkg::t_req free_req(logic [31:0] addr);
        tpba_pkg::t_req r;
        r.op           = tpba_pkg::OP_FREE;
        r.request_size = '0;
        r.address      = addr;
        return r;
    endfunction

    // stray frees hit arbitrary in-pool blocks, so the lists may loop
    function automatic tpba_pkg::t_req gen_item(int alloc_pct, int small_pct, bit allow_stray);
        tpba_pkg::t_req r;
        int unsigned    pick;
        int unsigned    code;
        r.op           = ($urandom_range(0, 99) < alloc_pct) ? tpba_pkg::OP_ALLOC
                                                             : tpba_pkg::OP_FREE;
        r.request_size = $urandom;
        r.address      = $urandom;
        pick = $urandom_range(0, 99);
        if (r.op == tpba_pkg::OP_ALLOC) begin
            if (pick < small_pct) begin
                r.request_size = $urandom_range(0, cfg_small_limit);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    r.request_size = $urandom_range(17, 190);
                end else if (pick < 70) begin
                    case ($urandom_range(0, 3))
                        0: r.request_size = 32'(cfg_small_limit);
                        1: r.request_size = 32'(cfg_small_limit) + 32'd1;
                        2: r.request_size = 32'(cfg_large_limit);
                        default: r.request_size = 32'(cfg_large_limit) + 32'd1;
                    endcase
                end else if (pick < 85) begin
                    r.request_size = $urandom_range(0, 255);
                end
            end
        end else begin
            code = $urandom_range(0, 1) ? (LARGE_TAG | $urandom_range(0, N_LARGE - 1))
                                        : $urandom_range(0, N_SMALL - 1);
            if (pick < 55 && live_blocks.size() != 0) begin
                r.address = block_addr(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
            end else if (pick < 62 && allow_stray) begin
                r.address = block_addr(code);
            end else if (pick < 72) begin
                r.address = block_addr(code) + $urandom_range(1, S_BYTES - 1);
            end else if (pick < 80) begin
                case ($urandom_range(0, 3))
                    0: r.address = cfg_small_base + N_SMALL * S_BYTES;
                    1: r.address = cfg_small_base - S_BYTES;
                    2: r.address = cfg_large_base + N_LARGE * L_BYTES;
                    default: r.address = cfg_large_base - L_BYTES;
                endcase
            end else if (pick < 85) begin
                r.address = '0;
            end
        end
        return r;
    endfunction

    task automatic issue(tpba_pkg::t_req r);
        while (requests_waiting.size() >= 4)
            @(posedge i_clk);
        requests_waiting.push_back(r);
        items_issued++;
    endtask

    task automatic run_phase(int count, int alloc_pct, int small_pct, bit allow_stray);
        for (int n = 0; n < count; n++)
            issue(gen_item(alloc_pct, small_pct, allow_stray));
    endtask

    task automatic wait_idle();
        while (items_accepted != items_issued || outcomes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(tpba_pkg::t_cfg_idx idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            tpba_pkg::CFG_SMALL_LIMIT: cfg_small_limit = data[4:0];
            tpba_pkg::CFG_LARGE_LIMIT: cfg_large_limit = data[7:0];
            tpba_pkg::CFG_SMALL_BASE:  cfg_small_base  = data;
            tpba_pkg::CFG_LARGE_BASE:  cfg_large_base  = data;
            default: ;
        endcase
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            req_gap = 0;
        end else begin
            if (i_req_valid && !o_req_stall) begin
                outcomes_due.push_back(pool_outcome(i_req));
                items_accepted++;
                req_gap = draw_wait(req_steady);
            end
            if (!i_req_valid || !o_req_stall) begin
                if (req_gap > 0) begin
                    req_gap--;
                    i_req_valid <= 1'b0;
                end else if (requests_waiting.size() != 0) begin
                    i_req       <= requests_waiting.pop_front();
                    i_req_valid <= 1'b1;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_stall <= 1'b0;
            rsp_wait = 0;
        end else begin
            if (o_rsp_valid && !i_rsp_stall) begin
                if (outcomes_due.size() == 0) begin
                    $error("response with nothing outstanding: block_address %h status %0d",
                           o_rsp.block_address, o_rsp.status);
                    mismatches++;
                end else begin
                    rsp_want = outcomes_due.pop_front();
                    if (o_rsp.block_address !== rsp_want.block_address) begin
                        $error("block_address: expected %h, got %h",
                               rsp_want.block_address, o_rsp.block_address);
                        mismatches++;
                    end
                    if (o_rsp.status !== rsp_want.status) begin
                        $error("status: expected %0d, got %0d", rsp_want.status, o_rsp.status);
                        mismatches++;
                    end
                end
                rsp_wait = draw_wait(rsp_steady);
            end
            if (hold_taken != hold_asked) begin
                hold_taken = hold_asked;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_rsp_stall <= 1'b1;
            end else if (rsp_wait > 0) begin
                rsp_wait--;
                i_rsp_stall <= 1'b1;
            end else begin
                i_rsp_stall <= 1'b0;
            end
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_two_pool_block_allocator: FAIL");
        $finish;
    end

    initial begin
        cfg_small_limit = tpba_pkg::SMALL_LIMIT_RST;
        cfg_large_limit = tpba_pkg::LARGE_LIMIT_RST;
        cfg_small_base  = tpba_pkg::SMALL_BASE_RST;
        cfg_large_base  = tpba_pkg::LARGE_BASE_RST;
        for (int i = 0; i < N_SMALL; i++)
            small_link[i] = 11'(i + 1);
        for (int i = 0; i < N_LARGE; i++)
            large_link[i] = 8'(i + 1);
        small_top  = '0;
        large_top  = '0;
        alloc_seen = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset register values
        issue(free_req(32'd4096));              // free before any allocate
        issue(free_req(32'd0));
        issue(alloc_req(32'd0));                // zero size counts as one
        issue(alloc_req(32'd15));
        issue(alloc_req(32'd16));
        issue(alloc_req(32'd180));
        issue(alloc_req(32'd181));              // too large
        issue(alloc_req(32'hFFFF_FFFF));
        issue(free_req(32'd0));                 // null
        issue(free_req(32'd4097));              // misaligned
        issue(free_req(32'd4096 + N_SMALL * S_BYTES));
        issue(free_req(32'd65536 + N_LARGE * L_BYTES));
        issue(free_req(32'd65537));
        issue(free_req(32'hFFFF_FFFF));
        issue(free_req(32'd4112));
        issue(free_req(32'd65720));
        issue(alloc_req(32'd1));
        issue(alloc_req(32'd100));
        wait_idle();

        // mostly small allocates: the small pool runs dry
        write_reg(tpba_pkg::CFG_SMALL_LIMIT, 32'd16);
        write_reg(tpba_pkg::CFG_LARGE_LIMIT, 32'd184);
        write_reg(tpba_pkg::CFG_SMALL_BASE, 32'd1);
        run_phase(1300, 97, 90, 1'b0);
        wait_idle();

        // pools overlap at the top of the address space; long response hold
        write_reg(tpba_pkg::CFG_SMALL_LIMIT, 32'd8);
        write_reg(tpba_pkg::CFG_LARGE_LIMIT, 32'd100);
        write_reg(tpba_pkg::CFG_SMALL_BASE, 32'd4294950911);
        write_reg(tpba_pkg::CFG_LARGE_BASE, 32'd4294943743);
        req_steady = 1'b1;
        hold_asked++;
        issue(free_req(cfg_small_base));        // double free loops the list
        issue(free_req(cfg_small_base));
        issue(alloc_req(32'd1));
        issue(alloc_req(32'd1));
        run_phase(200, 50, 40, 1'b1);
        wait_idle();

        // nothing routed to the small pool, small pool wraps through zero
        req_steady = 1'b1;
        rsp_steady = 1'b1;
        write_reg(tpba_pkg::CFG_SMALL_LIMIT, 32'd0);
        write_reg(tpba_pkg::CFG_LARGE_LIMIT, 32'd255);
        write_reg(tpba_pkg::CFG_SMALL_BASE, 32'hFFFF_FF00);
        write_reg(tpba_pkg::CFG_LARGE_BASE, 32'h0000_0100);
        issue(free_req(32'd0));                 // null even though in the pool
        run_phase(120, 45, 40, 1'b1);
        wait_idle();

        req_steady = 1'b0;
        rsp_steady = 1'b0;
        write_reg(tpba_pkg::CFG_SMALL_LIMIT, 32'd31);
        write_reg(tpba_pkg::CFG_LARGE_LIMIT, 32'd1);
        write_reg(tpba_pkg::CFG_SMALL_BASE, $urandom);
        write_reg(tpba_pkg::CFG_LARGE_BASE, 32'd1);
        run_phase(80, 50, 60, 1'b1);
        wait_idle();

        write_reg(tpba_pkg::CFG_SMALL_LIMIT, 32'(tpba_pkg::SMALL_LIMIT_RST));
        write_reg(tpba_pkg::CFG_LARGE_LIMIT, 32'(tpba_pkg::LARGE_LIMIT_RST));
        write_reg(tpba_pkg::CFG_SMALL_BASE, tpba_pkg::SMALL_BASE_RST);
        write_reg(tpba_pkg::CFG_LARGE_BASE, tpba_pkg::LARGE_BASE_RST);
        run_phase(50, 50, 40, 1'b1);
        wait_idle();

        if (mismatches == 0 && outcomes_due.size() == 0)
            $display("tb_two_pool_block_allocator: PASS");
        else
            $display("tb_two_pool_block_allocator: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
